### hdl/rmtt_pkg.sv
package rmtt_pkg;

  localparam int MEM_ENTRIES = 64;
  localparam int IDX_W       = (MEM_ENTRIES > 1) ? $clog2(MEM_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MEM_ENTRIES + 1);
  localparam int REG_W       = 20;
  localparam int ADDR_W      = 32;
  localparam int RTYPE_W     = 2;
  localparam int REGID_W     = 5;
  localparam int EVT_W       = 4;
  localparam int COUNT_OUT_W = 7;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  typedef enum logic [RTYPE_W-1:0] {
    REQ_MEM_READ  = 2'd0,
    REQ_MEM_WRITE = 2'd1,
    REQ_REG_MOVE  = 2'd2,
    REQ_TAINT_SRC = 2'd3
  } req_kind_t;

  typedef enum logic [EVT_W-1:0] {
    EV_NONE        = 4'd0,
    EV_REG_TAINTED = 4'd1,
    EV_REG_CLEARED = 4'd2,
    EV_MEM_CLEARED = 4'd3,
    EV_MEM_KEPT    = 4'd4,
    EV_MEM_ADDED   = 4'd5,
    EV_MOVE_CLEAR  = 4'd6,
    EV_MOVE_TAINT  = 4'd7,
    EV_SRC_ADDED   = 4'd8,
    EV_TABLE_FULL  = 4'd9
  } evt_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_EXEC
  } back_state_t;

  typedef struct packed {
    req_kind_t         kind;
    logic [ADDR_W-1:0] addr;
    logic [REG_W-1:0]  d_sel;
    logic [REG_W-1:0]  d_chain;
    logic [REG_W-1:0]  w_sel;
    logic [REG_W-1:0]  w_chain;
    logic              w_none;
  } item_t;

  // alias chain length for register codes 1..20, code 0 unused
  localparam logic [2:0] CHAIN_LEN [0:REG_W] = '{
    3'd0, 3'd4, 3'd3, 3'd2, 3'd1, 3'd4, 3'd3, 3'd2, 3'd1, 3'd4, 3'd3,
    3'd2, 3'd1, 3'd4, 3'd3, 3'd2, 3'd1, 3'd2, 3'd1, 3'd2, 3'd1
  };

  function automatic logic is_tracked(logic [REGID_W-1:0] r);
    return (r != '0) && (r <= REGID_W'(REG_W));
  endfunction

  function automatic logic [REG_W-1:0] reg_sel(logic [REGID_W-1:0] r);
    logic [REG_W-1:0] m;
    m = '0;
    if (is_tracked(r)) begin
      m = REG_W'(1) << (r - REGID_W'(1));
    end
    return m;
  endfunction

  function automatic logic [REG_W-1:0] chain_mask(logic [REGID_W-1:0] r);
    logic [REG_W-1:0] ones;
    logic [REG_W-1:0] m;
    ones = '0;
    m    = '0;
    if (is_tracked(r)) begin
      ones = ~({REG_W{1'b1}} << CHAIN_LEN[r]);
      m    = ones << (r - REGID_W'(1));
    end
    return m;
  endfunction

endpackage

### hdl/register_memory_taint_tracker_unit.sv
// Register and memory taint tracker. Items enter through a two-entry queue, so
// up to two items are taken while earlier work or a waiting result is pending;
// every item gives exactly one result. Memory read, memory write and taint
// source items scan the address table through its single read port, one
// entry per cycle, stopping at the first match; when nothing matches the scan
// covers the whole table, as it does before any insert of a new address. A
// register move needs no scan. The table size is set by MEM_ENTRIES in the
// package; tainted_count shows the low 7 bits of the entry count.
module register_memory_taint_tracker_unit
  import rmtt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [RTYPE_W-1:0]     req_type,
  input  logic [ADDR_W-1:0]      mem_address,
  input  logic [REGID_W-1:0]     data_reg,
  input  logic [REGID_W-1:0]     dest_reg,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [EVT_W-1:0]       event_code,
  output logic [REG_W-1:0]       reg_taint_bits,
  output logic [COUNT_OUT_W-1:0] tainted_count
);

  logic  q_full;
  logic  push;
  item_t push_item;
  logic  pop;
  logic  q_valid;
  item_t head;

  rmtt_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .mem_address (mem_address),
    .data_reg    (data_reg),
    .dest_reg    (dest_reg),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item)
  );

  rmtt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  rmtt_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_code     (event_code),
    .reg_taint_bits (reg_taint_bits),
    .tainted_count  (tainted_count)
  );

endmodule

### hdl/rmtt_front.sv
module rmtt_front
  import rmtt_pkg::*;
(
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [RTYPE_W-1:0] req_type,
  input  logic [ADDR_W-1:0]  mem_address,
  input  logic [REGID_W-1:0] data_reg,
  input  logic [REGID_W-1:0] dest_reg,
  input  logic               q_full,
  output logic               push,
  output item_t              push_item
);

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_item.kind    = req_kind_t'(req_type);
    push_item.addr    = mem_address;
    push_item.d_sel   = reg_sel(data_reg);
    push_item.d_chain = chain_mask(data_reg);
    push_item.w_sel   = reg_sel(dest_reg);
    push_item.w_chain = chain_mask(dest_reg);
    push_item.w_none  = (dest_reg == '0);
  end

endmodule

### hdl/rmtt_queue.sv
module rmtt_queue
  import rmtt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  q_valid,
  output item_t head
);

  item_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign q_valid = (count != '0);
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

### hdl/rmtt_back.sv
module rmtt_back
  import rmtt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  item_t                  head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [EVT_W-1:0]       event_code,
  output logic [REG_W-1:0]       reg_taint_bits,
  output logic [COUNT_OUT_W-1:0] tainted_count
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(MEM_ENTRIES - 1);

  back_state_t state, state_next;

  item_t              item;
  logic [ADDR_W-1:0]  mem [MEM_ENTRIES];
  logic [ADDR_W-1:0]  rdata;
  logic [MEM_ENTRIES-1:0] valid;
  logic [CNT_W-1:0]   entry_count;
  logic [CNT_W-1:0]   entry_count_next;
  logic [REG_W-1:0]   reg_taint;
  logic [REG_W-1:0]   reg_taint_next;
  logic [IDX_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   rd_idx;
  logic               rd_pending;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;

  logic               cmp_hit;
  logic               scan_done;
  logic               exec_fire;
  logic               out_free;
  logic               mem_we;
  logic               valid_set;
  logic               valid_clr;
  logic               d_t;
  logic               w_t;
  evt_t               ev;

  assign out_free  = !out_valid || out_ready;
  assign cmp_hit   = rd_pending && valid[rd_idx] && (rdata == item.addr);
  assign scan_done = rd_pending && (cmp_hit || (rd_idx == LAST));
  assign d_t       = |(reg_taint & item.d_sel);
  assign w_t       = |(reg_taint & item.w_sel);

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          state_next = (head.kind == REQ_REG_MOVE) ? B_EXEC : B_SCAN;
        end
      end
      B_SCAN: begin
        if (scan_done) begin
          state_next = B_EXEC;
        end
      end
      B_EXEC: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state == B_IDLE) && q_valid;
    exec_fire = (state == B_EXEC) && out_free;
  end

  // result of the item held in the work registers
  always_comb begin
    ev               = EV_NONE;
    reg_taint_next   = reg_taint;
    entry_count_next = entry_count;
    mem_we           = 1'b0;
    valid_set        = 1'b0;
    valid_clr        = 1'b0;
    unique case (item.kind)
      REQ_MEM_READ: begin
        if (hit) begin
          ev = EV_REG_TAINTED;
          if (!d_t) begin
            reg_taint_next = reg_taint | item.d_chain;
          end
        end else if (d_t) begin
          ev             = EV_REG_CLEARED;
          reg_taint_next = reg_taint & ~item.d_chain;
        end
      end
      REQ_MEM_WRITE: begin
        if (hit) begin
          if (!d_t) begin
            ev               = EV_MEM_CLEARED;
            valid_clr        = 1'b1;
            entry_count_next = entry_count - CNT_W'(1);
          end else begin
            ev = EV_MEM_KEPT;
          end
        end else if (d_t) begin
          if (free_found) begin
            ev               = EV_MEM_ADDED;
            mem_we           = 1'b1;
            valid_set        = 1'b1;
            entry_count_next = entry_count + CNT_W'(1);
          end else begin
            ev = EV_TABLE_FULL;
          end
        end
      end
      REQ_REG_MOVE: begin
        if (!item.w_none) begin
          if (w_t && !d_t) begin
            ev             = EV_MOVE_CLEAR;
            reg_taint_next = reg_taint & ~item.w_chain;
          end else if (!w_t && d_t && (item.w_sel != '0)) begin
            ev             = EV_MOVE_TAINT;
            reg_taint_next = reg_taint | item.w_chain;
          end
        end
      end
      REQ_TAINT_SRC: begin
        if (hit) begin
          ev = EV_SRC_ADDED;
        end else if (free_found) begin
          ev               = EV_SRC_ADDED;
          mem_we           = 1'b1;
          valid_set        = 1'b1;
          entry_count_next = entry_count + CNT_W'(1);
        end else begin
          ev = EV_TABLE_FULL;
        end
      end
      default: ev = EV_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      reg_taint   <= '0;
      valid       <= '0;
      entry_count <= '0;
      out_valid   <= 1'b0;
      rd_pending  <= 1'b0;
      hit         <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        rd_pending <= 1'b0;
        hit        <= 1'b0;
        free_found <= 1'b0;
      end
      if (state == B_SCAN) begin
        rd_pending <= 1'b1;
        if (cmp_hit) begin
          hit <= 1'b1;
        end
        if (rd_pending && !valid[rd_idx] && !free_found) begin
          free_found <= 1'b1;
        end
      end
      if (exec_fire) begin
        reg_taint   <= reg_taint_next;
        entry_count <= entry_count_next;
        if (valid_set) begin
          valid[free_idx] <= 1'b1;
        end
        if (valid_clr) begin
          valid[hit_idx] <= 1'b0;
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item     <= head;
      scan_idx <= '0;
    end else if ((state == B_SCAN) && (scan_idx != LAST)) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    rd_idx <= scan_idx;
    if ((state == B_SCAN) && cmp_hit) begin
      hit_idx <= rd_idx;
    end
    if ((state == B_SCAN) && rd_pending && !valid[rd_idx] && !free_found) begin
      free_idx <= rd_idx;
    end
    if (exec_fire) begin
      event_code     <= ev;
      reg_taint_bits <= reg_taint_next;
      tainted_count  <= COUNT_OUT_W'(entry_count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire && mem_we) begin
      mem[free_idx] <= item.addr;
    end
    rdata <= mem[scan_idx];
  end

endmodule

### hdl/rmtt_checker.sv
module rmtt_checker
  import rmtt_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [EVT_W-1:0]       event_code,
  input logic [REG_W-1:0]       reg_taint_bits,
  input logic [COUNT_OUT_W-1:0] tainted_count
);

  localparam logic [COUNT_OUT_W-1:0] FULL_COUNT = COUNT_OUT_W'(MEM_ENTRIES);
  localparam logic                   NARROW     = (MEM_ENTRIES < 128);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_code)
      && $stable(reg_taint_bits) && $stable(tainted_count))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !NARROW || (tainted_count <= FULL_COUNT))
    else $error("entry count above table size");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_code == EV_TABLE_FULL) |-> !NARROW || (tainted_count == FULL_COUNT))
    else $error("table full reported with free entries");

  a_cleared_room: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_code == EV_MEM_CLEARED) |-> !NARROW || (tainted_count < FULL_COUNT))
    else $error("entry removed but count still at full");

endmodule

bind register_memory_taint_tracker_unit rmtt_checker u_rmtt_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .event_code     (event_code),
  .reg_taint_bits (reg_taint_bits),
  .tainted_count  (tainted_count)
);
